// ----- src/lfrs_pkg.sv -----
`timescale 1ns / 1ps

package lfrs_pkg;

    localparam int NUM_ROOMS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int TIME_W        = 32;
    localparam int ATIME_W       = 48;
    localparam int COUNT_W       = 32;
    localparam int ROOM_W        = 4;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 136;
    localparam int OUT_USER_W    = 2;

    localparam logic [CFG_W-1:0]   NUM_ROOMS_RST = 5'd16;
    localparam logic [ATIME_W-1:0] ATIME_MAX     = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    typedef enum logic [2:0] {
        S_WAIT   = 3'd0,
        S_SCAN   = 3'd1,
        S_DRAIN  = 3'd2,
        S_PICK   = 3'd3,
        S_COMMIT = 3'd4,
        S_DONE   = 3'd5
    } step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_READ,
        OP_PICK,
        OP_COMMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        unique case (s)
            S_WAIT:   w = '{op: OP_ACCEPT, cond: C_NO_INPUT, target: S_WAIT};
            S_SCAN:   w = '{op: OP_READ,   cond: C_MORE,     target: S_SCAN};
            S_DRAIN:  w = '{op: OP_NOP,    cond: C_NEVER,    target: S_WAIT};
            S_PICK:   w = '{op: OP_PICK,   cond: C_NEVER,    target: S_WAIT};
            S_COMMIT: w = '{op: OP_COMMIT, cond: C_OUT_BUSY, target: S_COMMIT};
            S_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT};
            default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- src/lowest_free_room_scheduler.sv -----
`timescale 1ns / 1ps

// Meeting room allocator. Each request word (start, end) is booked into the
// lowest-numbered active room free at its start, or else into the room that
// frees earliest, with the start pushed back and the duration kept. One
// result word per request gives the room, real start and end, delayed and
// out-of-order flags, and the most-booked room with its count. For each
// request a small microcode program scans the active rooms of the room
// table one entry per cycle through its single read port, then picks,
// updates and loads the output register. The next request
// is taken while a result still waits on the output.
module lowest_free_room_scheduler
    import lfrs_pkg::*;
#(
    parameter int NUM_ROOMS = NUM_ROOMS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,       // num_rooms
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,        // start_time, end_time
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,        // room, actual_start, actual_end,
                                                  // best_room, best_count
    output logic [OUT_USER_W-1:0] m_tuser         // delayed, out_of_order
);

    localparam int RW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
    localparam int CW = $clog2(NUM_ROOMS + 1);

    // room tables
    logic [ATIME_W-1:0] busy_mem [NUM_ROOMS];
    logic [COUNT_W-1:0] cnt_mem  [NUM_ROOMS];
    logic [NUM_ROOMS-1:0] vld_reg;

    step_t step_reg, step_next;
    ctrl_t cw;
    logic  jump;

    logic [CFG_W-1:0]   num_rooms_reg;
    logic [CW-1:0]      act_n;
    logic [CW-1:0]      idx_reg;
    logic [RW-1:0]      rd_addr;
    logic [ATIME_W-1:0] busy_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic               rd_vld_reg;
    logic               pend_reg;
    logic [RW-1:0]      eval_idx_reg;
    logic [ATIME_W-1:0] bu;

    logic [TIME_W-1:0]  start_reg, dur_reg, prev_start_reg;
    logic               ooo_reg;
    logic               found_reg;
    logic [RW-1:0]      found_idx_reg;
    logic [RW-1:0]      earl_idx_reg;
    logic [ATIME_W-1:0] earl_val_reg;

    logic [RW-1:0]      room_reg, pick_room;
    logic [ATIME_W-1:0] astart_reg, pick_start;
    logic [ATIME_W-1:0] aend_reg;
    logic [ATIME_W:0]   aend_sum;
    logic               delayed_reg;

    logic [RW-1:0]      leader_reg;
    logic [COUNT_W-1:0] leader_cnt_reg;
    logic [COUNT_W-1:0] cnt_cur, cnt_inc;
    logic               take_lead;

    logic               out_busy, commit;
    logic               m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;

    logic [TIME_W-1:0]  in_start, in_end;

    assign in_start = s_tdata[TIME_W-1:0];
    assign in_end   = s_tdata[2*TIME_W-1:TIME_W];

    assign cfg_ready = 1'b1;
    assign s_tready  = (cw.op == OP_ACCEPT);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign out_busy = m_valid_reg && !m_tready;
    assign commit   = (cw.op == OP_COMMIT) && !out_busy;

    always_comb begin
        if (num_rooms_reg == '0) begin
            act_n = CW'(1);
        end else if (int'(num_rooms_reg) > NUM_ROOMS) begin
            act_n = CW'(NUM_ROOMS);
        end else begin
            act_n = CW'(num_rooms_reg);
        end
    end

    // sequencer
    always_comb begin
        cw = ucode(step_reg);
        unique case (cw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !s_tvalid;
            C_MORE:     jump = (idx_reg + CW'(1)) < act_n;
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b1;
        endcase
        if (jump) begin
            step_next = cw.target;
        end else begin
            step_next = step_t'(step_reg + 3'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rooms_reg <= NUM_ROOMS_RST;
        end else if (cfg_valid) begin
            num_rooms_reg <= cfg_data;
        end
    end

    // table read and write; the picked room stays addressed while commit waits
    assign rd_addr = ((cw.op == OP_PICK) || (cw.op == OP_COMMIT)) ? pick_room
                                                                  : idx_reg[RW-1:0];

    always_ff @(posedge aclk) begin
        busy_rd_reg <= busy_mem[rd_addr];
        cnt_rd_reg  <= cnt_mem[rd_addr];
        if (commit) begin
            busy_mem[room_reg] <= aend_reg;
            cnt_mem[room_reg]  <= cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (commit) begin
            vld_reg[room_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= vld_reg[rd_addr];
    end

    assign bu = rd_vld_reg ? busy_rd_reg : '0;

    // scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= (cw.op == OP_READ);
        end
        eval_idx_reg <= idx_reg[RW-1:0];
        if (cw.op == OP_ACCEPT) begin
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            earl_idx_reg  <= '0;
            earl_val_reg  <= ATIME_MAX;
        end else begin
            if (cw.op == OP_READ) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (pend_reg) begin
                if (!found_reg && bu <= {{(ATIME_W-TIME_W){1'b0}}, start_reg}) begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= eval_idx_reg;
                end
                if (bu < earl_val_reg) begin
                    earl_idx_reg <= eval_idx_reg;
                    earl_val_reg <= bu;
                end
            end
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_start_reg <= '0;
        end else if (s_tvalid && s_tready) begin
            prev_start_reg <= in_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            start_reg <= in_start;
            dur_reg   <= (in_end > in_start) ? (in_end - in_start) : '0;
            ooo_reg   <= in_start < prev_start_reg;
        end
    end

    // pick
    assign pick_room  = found_reg ? found_idx_reg : earl_idx_reg;
    assign pick_start = found_reg ? {{(ATIME_W-TIME_W){1'b0}}, start_reg} : earl_val_reg;
    assign aend_sum   = {1'b0, pick_start} + {{(ATIME_W+1-TIME_W){1'b0}}, dur_reg};

    always_ff @(posedge aclk) begin
        if (cw.op == OP_PICK) begin
            room_reg    <= pick_room;
            astart_reg  <= pick_start;
            aend_reg    <= aend_sum[ATIME_W] ? ATIME_MAX : aend_sum[ATIME_W-1:0];
            delayed_reg <= !found_reg;
        end
    end

    // commit
    assign cnt_cur   = rd_vld_reg ? cnt_rd_reg : '0;
    assign cnt_inc   = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
    assign take_lead = (room_reg == leader_reg) || (cnt_inc > leader_cnt_reg) ||
                       ((cnt_inc == leader_cnt_reg) && (room_reg < leader_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leader_reg     <= '0;
            leader_cnt_reg <= '0;
        end else if (commit && take_lead) begin
            leader_reg     <= room_reg;
            leader_cnt_reg <= cnt_inc;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {take_lead ? cnt_inc : leader_cnt_reg,
                           ROOM_W'(take_lead ? room_reg : leader_reg),
                           aend_reg,
                           astart_reg,
                           ROOM_W'(room_reg)};
            m_user_reg <= {ooo_reg, delayed_reg};
        end
    end

endmodule

// ----- dv/lowest_free_room_scheduler_tb.sv -----
`timescale 1ns / 1ps

module lowest_free_room_scheduler_tb
    import lfrs_pkg::*;
();

    typedef struct packed {
        logic [TIME_W-1:0] stop_t;
        logic [TIME_W-1:0] start_t;
    } request_t;

    typedef struct packed {
        logic [ROOM_W-1:0]  room;
        logic [ATIME_W-1:0] act_start;
        logic [ATIME_W-1:0] act_end;
        logic               delayed;
        logic               late;
        logic [ROOM_W-1:0]  best_room;
        logic [COUNT_W-1:0] best_count;
    } booking_t;

    localparam int PHASE_ITEMS = 70;
    localparam int FILL_ITEMS  = 20;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    request_t request_q[$];
    booking_t booking_q[$];

    // scheduler shadow state
    logic [ATIME_W-1:0] room_busy [NUM_ROOMS_DEF];
    logic [COUNT_W-1:0] room_hits [NUM_ROOMS_DEF];
    logic [ROOM_W-1:0]  top_room;
    logic [TIME_W-1:0]  last_start;
    logic [CFG_W-1:0]   room_cfg;

    int  fail_count;
    bit  in_fire;
    bit  idle_en;
    bit  hold_req;
    int  hold_left;

    lowest_free_room_scheduler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic booking_t book_room(input request_t rq);
        int               active;
        int               pick;
        int               soonest;
        bit               found;
        logic [63:0]      span;
        logic [63:0]      sum;
        booking_t         b;
        active = (room_cfg == 0) ? 1 :
                 ((room_cfg > NUM_ROOMS_DEF) ? NUM_ROOMS_DEF : int'(room_cfg));
        found   = 1'b0;
        pick    = 0;
        soonest = 0;
        for (int i = 0; i < active; i++) begin
            if (!found && room_busy[i] <= {16'h0, rq.start_t}) begin
                found = 1'b1;
                pick  = i;
            end
            if (room_busy[i] < room_busy[soonest])
                soonest = i;
        end
        span = (rq.stop_t > rq.start_t) ? 64'(rq.stop_t - rq.start_t) : 64'd0;
        b.delayed   = !found;
        b.room      = found ? ROOM_W'(pick) : ROOM_W'(soonest);
        b.act_start = found ? {16'h0, rq.start_t} : room_busy[soonest];
        sum         = {16'h0, b.act_start} + span;
        b.act_end   = (sum > {16'h0, ATIME_MAX}) ? ATIME_MAX : sum[ATIME_W-1:0];
        room_busy[b.room] = b.act_end;
        if (room_hits[b.room] != COUNT_MAX)
            room_hits[b.room] = room_hits[b.room] + 1'b1;
        if (room_hits[b.room] > room_hits[top_room] ||
            (room_hits[b.room] == room_hits[top_room] && b.room < top_room))
            top_room = b.room;
        b.late       = rq.start_t < last_start;
        last_start   = rq.start_t;
        b.best_room  = top_room;
        b.best_count = room_hits[top_room];
        return b;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic check_booking();
        booking_t want;
        booking_t got;
        got.room       = m_tdata[3:0];
        got.act_start  = m_tdata[51:4];
        got.act_end    = m_tdata[99:52];
        got.best_room  = m_tdata[103:100];
        got.best_count = m_tdata[135:104];
        got.delayed    = m_tuser[0];
        got.late       = m_tuser[1];
        if (booking_q.size() == 0) begin
            fail_count++;
            $display("%0t: result word mismatch, expected none, got %0h / %0h",
                     $time, m_tdata, m_tuser);
        end else begin
            want = booking_q.pop_front();
            check_field("room",         64'(want.room),       64'(got.room));
            check_field("actual_start", 64'(want.act_start),  64'(got.act_start));
            check_field("actual_end",   64'(want.act_end),    64'(got.act_end));
            check_field("delayed",      64'(want.delayed),    64'(got.delayed));
            check_field("out_of_order", 64'(want.late),       64'(got.late));
            check_field("best_room",    64'(want.best_room),  64'(got.best_room));
            check_field("best_count",   64'(want.best_count), 64'(got.best_count));
        end
    endtask

    // sample both channels
    always @(posedge aclk) begin
        in_fire = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                booking_q.push_back(book_room(request_q.pop_front()));
                in_fire = 1'b1;
            end
            if (m_tvalid && m_tready)
                check_booking();
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (!(s_tvalid && !in_fire)) begin
            if (request_q.size() > 0 && !(idle_en && $urandom_range(0, 99) < 20)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= request_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_en && $urandom_range(0, 99) < 20);
        end
    end

    task automatic set_rooms(input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        room_cfg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (request_q.size() != 0 || booking_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_req(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] sp);
        request_t rq;
        rq.start_t = st;
        rq.stop_t  = sp;
        request_q.push_back(rq);
    endtask

    initial begin
        logic [CFG_W-1:0]  phase_cfg [12];
        logic [TIME_W-1:0] gen_time;
        logic [TIME_W-1:0] st;
        logic [TIME_W-1:0] sp;
        int                r;

        phase_cfg = '{5'd1, 5'd2, 5'd3, 5'd16, 5'd4, 5'd31,
                      5'd7, 5'd0, 5'd17, 5'd10, 5'd16, 5'd9};
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        fail_count = 0;
        in_fire    = 1'b0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        hold_left  = 0;
        for (int i = 0; i < NUM_ROOMS_DEF; i++) begin
            room_busy[i] = '0;
            room_hits[i] = '0;
        end
        top_room   = '0;
        last_start = '0;
        room_cfg   = NUM_ROOMS_RST;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset room count
        push_req(32'd0, 32'd10);
        push_req(32'd0, 32'd10);
        push_req(32'd5, 32'd3);
        push_req(32'd7, 32'd7);
        push_req(32'd20, 32'd30);
        push_req(32'd15, 32'd25);
        push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        push_req(32'd0, 32'hFFFF_FFFF);
        push_req(32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // zero count behaves as one room
        set_rooms(5'd0);
        push_req(32'd1000, 32'd1100);
        push_req(32'd1000, 32'd1100);
        push_req(32'd1050, 32'd1060);
        push_req(32'd1040, 32'd1040);
        drain();

        // oversized count clamps
        set_rooms(5'd31);
        for (int i = 0; i < 6; i++)
            push_req(32'd2000, 32'd2000 + 32'(i) * 32'd7 + 32'd1);
        push_req(32'd1999, 32'd2500);
        drain();

        // random, well-formed with occasional back-steps and empty meetings
        gen_time = 32'd10000;
        for (int p = 0; p < 12; p++) begin
            set_rooms(phase_cfg[p]);
            idle_en  = (p != 3);
            gen_time = gen_time + 32'd5000;
            if (p == 5)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                gen_time = gen_time + 32'($urandom_range(0, 12));
                r  = $urandom_range(0, 99);
                st = (r < 4) ? gen_time - 32'($urandom_range(1, 20)) : gen_time;
                sp = st + 32'($urandom_range(1, 80));
                if (r >= 4 && r < 8)
                    sp = st - 32'($urandom_range(0, 5));
                push_req(st, sp);
            end
            drain();
        end

        // full-range noise
        set_rooms(5'($urandom_range(0, 31)));
        idle_en  = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) begin
            st = $urandom;
            r  = $urandom_range(0, 2);
            sp = (r == 0) ? st : $urandom;
            push_req(st, sp);
        end
        drain();

        // one room, maximal durations: busy time climbs well past 32 bits
        set_rooms(5'd1);
        idle_en = 1'b0;
        for (int k = 0; k < FILL_ITEMS; k++)
            push_req(32'd0, 32'hFFFF_FFFF);
        drain();

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && booking_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
